FILE: src/cst_pkg.sv
package cst_pkg;

  // Command codes
  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_P      = 2'd2,
    CMD_V      = 2'd3
  } cst_cmd_t;

  // Width of the slot field; create only searches slots it can name
  localparam int SLOT_W     = 4;
  localparam int SLOT_SPAN  = 1 << SLOT_W;
  localparam int INIT_CNT_W = 16;

  // Input item
  typedef struct packed {
    cst_cmd_t                      cmd;
    logic [SLOT_W-1:0]             sem_id;
    logic signed [INIT_CNT_W-1:0]  initial_count;
  } cst_in_t;

  // Result item
  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic              must_wait;
    logic              wake_one;
  } cst_out_t;

  // Command and partial result as it travels down the cell row
  typedef struct packed {
    cst_cmd_t          cmd;
    logic [SLOT_W-1:0] sem_id;
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic              must_wait;
    logic              wake_one;
  } cst_tok_t;

endpackage

FILE: src/cst_cell.sv
module cst_cell #(
  parameter int IDX         = 0,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_v,
  input  cst_pkg::cst_tok_t        in_tok,
  input  logic [COUNT_WIDTH-1:0]   in_cnt,
  output logic                     out_v,
  output cst_pkg::cst_tok_t        out_tok,
  output logic [COUNT_WIDTH-1:0]   out_cnt
);
  import cst_pkg::*;

  // Only slots the 4-bit id can name are addressed or handed out
  localparam bit                     ADDRESSABLE = (IDX < SLOT_SPAN);
  localparam logic [SLOT_W-1:0]      SLOT_ID     = SLOT_W'(IDX);
  localparam logic [COUNT_WIDTH-1:0] CNT_MIN     = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX     = {1'b0, {(COUNT_WIDTH-1){1'b1}}};

  logic                   in_use_r, in_use_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   v_r;
  cst_tok_t               tok_r, tok_nxt;
  logic [COUNT_WIDTH-1:0] pass_cnt_r;
  logic                   hit;

  // Apply the passing command to this slot
  always_comb begin
    tok_nxt    = in_tok;
    in_use_nxt = in_use_r;
    cnt_nxt    = cnt_r;
    hit        = ADDRESSABLE && (in_tok.sem_id == SLOT_ID);
    unique case (in_tok.cmd)
      CMD_CREATE: begin
        // ok doubles as "already claimed upstream"
        if (ADDRESSABLE && !in_tok.ok && !in_use_r) begin
          in_use_nxt   = 1'b1;
          cnt_nxt      = in_cnt;
          tok_nxt.ok   = 1'b1;
          tok_nxt.slot = SLOT_ID;
        end
      end
      CMD_FREE: begin
        if (hit && in_use_r && !cnt_r[COUNT_WIDTH-1] && (cnt_r != '0)) begin
          in_use_nxt = 1'b0;
          tok_nxt.ok = 1'b1;
        end
      end
      CMD_P: begin
        if (hit) begin
          if (cnt_r != CNT_MIN) cnt_nxt = cnt_r - COUNT_WIDTH'(1);
          tok_nxt.must_wait = cnt_nxt[COUNT_WIDTH-1];
        end
      end
      CMD_V: begin
        if (hit) begin
          if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + COUNT_WIDTH'(1);
          tok_nxt.wake_one = cnt_nxt[COUNT_WIDTH-1] || (cnt_nxt == '0);
        end
      end
    endcase
  end

  // Slot state and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      cnt_r    <= '0;
      v_r      <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
      if (in_v) begin
        in_use_r <= in_use_nxt;
        cnt_r    <= cnt_nxt;
      end
    end
  end

  // Item handed to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r      <= '0;
      pass_cnt_r <= '0;
    end else if (adv) begin
      tok_r      <= tok_nxt;
      pass_cnt_r <= in_cnt;
    end
  end

  assign out_v   = v_r;
  assign out_tok = tok_r;
  assign out_cnt = pass_cnt_r;

endmodule

FILE: src/counting_semaphore_table_unit.sv
// Counting semaphore table: NUM_SEMAPHORES cells in a row, one per slot, each
// holding an allocated mark and a saturating signed count. A command enters
// the first cell and moves one cell per cycle while the row advances; the cell
// it addresses (or, for create, the first free cell it passes) updates itself
// and fills in the result. Each cell registers the item as it passes; the row
// is a pipeline, so one item is accepted every cycle while the output side
// takes results, and the whole row holds while a finished result waits at the
// end with out_ready low. Only slots 0..15 can be addressed or created. Reset
// clears all marks and counts.
module counting_semaphore_table_unit #(
  parameter int NUM_SEMAPHORES = 16,
  parameter int COUNT_WIDTH    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cst_pkg::cst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cst_pkg::cst_out_t out_data
);
  import cst_pkg::*;

  localparam int EXT_W = (COUNT_WIDTH > INIT_CNT_W) ? COUNT_WIDTH : INIT_CNT_W;
  localparam logic signed [EXT_W-1:0] CLAMP_MAX =
    EXT_W'((64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] CLAMP_MIN = -CLAMP_MAX - EXT_W'(1);

  logic                          adv;
  logic signed [EXT_W-1:0]       init_ext;
  logic signed [EXT_W-1:0]       init_clamped;
  cst_tok_t                      entry_tok;
  logic                          chain_v   [NUM_SEMAPHORES+1];
  cst_tok_t                      chain_tok [NUM_SEMAPHORES+1];
  logic [COUNT_WIDTH-1:0]        chain_cnt [NUM_SEMAPHORES+1];

  // Whole row moves together unless a result is stuck at the end
  assign adv      = !chain_v[NUM_SEMAPHORES] || out_ready;
  assign in_ready = adv;

  // Clamp the create count into the count range and seed the result
  always_comb begin
    init_ext = EXT_W'(in_data.initial_count);
    if (init_ext > CLAMP_MAX)      init_clamped = CLAMP_MAX;
    else if (init_ext < CLAMP_MIN) init_clamped = CLAMP_MIN;
    else                           init_clamped = init_ext;

    entry_tok.cmd       = in_data.cmd;
    entry_tok.sem_id    = in_data.sem_id;
    entry_tok.ok        = (in_data.cmd == CMD_P) || (in_data.cmd == CMD_V);
    entry_tok.slot      = (in_data.cmd == CMD_CREATE) ? '0 : in_data.sem_id;
    entry_tok.must_wait = 1'b0;
    entry_tok.wake_one  = 1'b0;
  end

  assign chain_v[0]   = in_valid;
  assign chain_tok[0] = entry_tok;
  assign chain_cnt[0] = init_clamped[COUNT_WIDTH-1:0];

  // Row of slot cells
  for (genvar i = 0; i < NUM_SEMAPHORES; i++) begin : g_cell
    cst_cell #(
      .IDX         (i),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_v    (chain_v[i]),
      .in_tok  (chain_tok[i]),
      .in_cnt  (chain_cnt[i]),
      .out_v   (chain_v[i+1]),
      .out_tok (chain_tok[i+1]),
      .out_cnt (chain_cnt[i+1])
    );
  end

  // Result from the last cell
  assign out_valid          = chain_v[NUM_SEMAPHORES];
  assign out_data.ok        = chain_tok[NUM_SEMAPHORES].ok;
  assign out_data.slot      = chain_tok[NUM_SEMAPHORES].slot;
  assign out_data.must_wait = chain_tok[NUM_SEMAPHORES].must_wait;
  assign out_data.wake_one  = chain_tok[NUM_SEMAPHORES].wake_one;

endmodule

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int NUM_SEM     = 16;
  localparam int CNT_W       = 16;
  localparam int CNT_MAX     = (1 << (CNT_W - 1)) - 1;
  localparam int CNT_MIN     = -CNT_MAX - 1;
  localparam int RAND_ITEMS  = 1600;
  localparam int MAX_IDLE    = 12;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_WAIT  = 3 * NUM_SEM;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED  = 25;

  // One row of the directed table; lit marks a hand-typed expectation
  typedef struct packed {
    cst_in_t  item;
    bit       lit;
    cst_out_t want;
  } stim_row_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  cst_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cst_out_t out_data;

  // Expectation attached to the item currently offered
  bit       row_lit   = 1'b0;
  cst_out_t row_want  = '0;

  // Shadow semaphore table
  bit sem_alloc [NUM_SEM];
  int sem_count [NUM_SEM];

  cst_out_t pending_results[$];
  cst_out_t predicted;
  cst_out_t want;

  int  cycle_count;
  int  errors;
  int  items_taken;
  int  results_taken;
  int  refused_creates;
  int  released_slots;
  int  wait_flags;
  int  wake_flags;
  bit  stim_done;

  counting_semaphore_table_unit #(
    .NUM_SEMAPHORES(NUM_SEM),
    .COUNT_WIDTH   (CNT_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int clamp_count(int v);
    if (v > CNT_MAX) return CNT_MAX;
    if (v < CNT_MIN) return CNT_MIN;
    return v;
  endfunction

  // Applies one command to the shadow table and returns its result
  function automatic cst_out_t sem_table_apply(cst_in_t it);
    cst_out_t res;
    int       id;
    int       lim;
    bit       found;
    res      = '0;
    id       = int'(it.sem_id);
    res.slot = it.sem_id;
    lim      = (NUM_SEM < SLOT_SPAN) ? NUM_SEM : SLOT_SPAN;
    found    = 1'b0;
    case (it.cmd)
      CMD_CREATE: begin
        // lowest free slot wins
        res.slot = '0;
        for (int i = 0; i < lim; i++) begin
          if (!found && !sem_alloc[i]) begin
            found        = 1'b1;
            sem_alloc[i] = 1'b1;
            sem_count[i] = clamp_count(int'(it.initial_count));
            res.ok       = 1'b1;
            res.slot     = SLOT_W'(i);
          end
        end
      end
      CMD_FREE: begin
        if (id < NUM_SEM && sem_alloc[id] && sem_count[id] > 0) begin
          sem_alloc[id] = 1'b0;
          res.ok        = 1'b1;
        end
      end
      CMD_P: begin
        res.ok = 1'b1;
        if (id < NUM_SEM) begin
          if (sem_count[id] > CNT_MIN) sem_count[id]--;
          res.must_wait = (sem_count[id] < 0);
        end
      end
      CMD_V: begin
        res.ok = 1'b1;
        if (id < NUM_SEM) begin
          if (sem_count[id] < CNT_MAX) sem_count[id]++;
          res.wake_one = (sem_count[id] < 1);
        end
      end
    endcase
    return res;
  endfunction

  function automatic stim_row_t mk_row(cst_cmd_t c, logic [SLOT_W-1:0] id, int init, bit lit,
                                       bit ok, logic [SLOT_W-1:0] slot, bit w, bit k);
    stim_row_t r;
    r.item.cmd           = c;
    r.item.sem_id        = id;
    r.item.initial_count = init[INIT_CNT_W-1:0];
    r.lit                = lit;
    r.want.ok            = ok;
    r.want.slot          = slot;
    r.want.must_wait     = w;
    r.want.wake_one      = k;
    return r;
  endfunction

  // Handshake monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = sem_table_apply(in_data);
        pending_results.push_back(row_lit ? row_want : predicted);
        items_taken++;
        if (in_data.cmd == CMD_CREATE && !predicted.ok) refused_creates++;
        if (in_data.cmd == CMD_FREE && predicted.ok) released_slots++;
        if (predicted.must_wait) wait_flags++;
        if (predicted.wake_one) wake_flags++;
      end
      if (out_valid && out_ready) begin
        results_taken++;
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: ok=%0d slot=%0d", out_data.ok, out_data.slot);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_data.ok);
            errors++;
          end
          if (out_data.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_data.slot);
            errors++;
          end
          if (out_data.must_wait !== want.must_wait) begin
            $error("must_wait: expected %0d, got %0d", want.must_wait, out_data.must_wait);
            errors++;
          end
          if (out_data.wake_one !== want.wake_one) begin
            $error("wake_one: expected %0d, got %0d", want.wake_one, out_data.wake_one);
            errors++;
          end
        end
      end
    end
  end

  // Sender: directed table, then random command mix in phases
  initial begin
    stim_row_t directed [N_DIRECTED];
    stim_row_t r;
    cst_in_t   it;
    int        gap;
    int        pick;
    int        phase;
    int        t_create;
    int        t_free;
    int        t_p;
    int        sel;
    bit        burst;

    // unallocated slot still counts; free of an idle slot fails
    directed[0]  = mk_row(CMD_P,      4'd5,  0,      1'b1, 1'b1, 4'd5, 1'b1, 1'b0);
    directed[1]  = mk_row(CMD_V,      4'd5,  0,      1'b1, 1'b1, 4'd5, 1'b0, 1'b1);
    directed[2]  = mk_row(CMD_FREE,   4'd3,  0,      1'b1, 1'b0, 4'd3, 1'b0, 1'b0);
    // top of the count range, V saturates
    directed[3]  = mk_row(CMD_CREATE, 4'd9,  32767,  1'b1, 1'b1, 4'd0, 1'b0, 1'b0);
    directed[4]  = mk_row(CMD_V,      4'd0,  0,      1'b1, 1'b1, 4'd0, 1'b0, 1'b0);
    directed[5]  = mk_row(CMD_FREE,   4'd0,  0,      1'b1, 1'b1, 4'd0, 1'b0, 1'b0);
    // bottom of the range, P saturates, free refused on negative count
    directed[6]  = mk_row(CMD_CREATE, 4'd15, -32768, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0);
    directed[7]  = mk_row(CMD_P,      4'd0,  0,      1'b1, 1'b1, 4'd0, 1'b1, 1'b0);
    directed[8]  = mk_row(CMD_FREE,   4'd0,  0,      1'b1, 1'b0, 4'd0, 1'b0, 1'b0);
    // fill the rest of the table
    directed[9]  = mk_row(CMD_CREATE, 4'd0,  0,      1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[10] = mk_row(CMD_CREATE, 4'd1,  1,      1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[11] = mk_row(CMD_CREATE, 4'd2,  -1,     1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[12] = mk_row(CMD_CREATE, 4'd4,  2,      1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[13] = mk_row(CMD_CREATE, 4'd8,  100,    1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[14] = mk_row(CMD_CREATE, 4'd6,  -100,   1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[15] = mk_row(CMD_CREATE, 4'd7,  32767,  1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[16] = mk_row(CMD_CREATE, 4'd10, -32768, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[17] = mk_row(CMD_CREATE, 4'd11, 21845,  1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[18] = mk_row(CMD_CREATE, 4'd12, -21846, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[19] = mk_row(CMD_CREATE, 4'd13, 7,      1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[20] = mk_row(CMD_CREATE, 4'd14, 3,      1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[21] = mk_row(CMD_CREATE, 4'd3,  -2,     1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[22] = mk_row(CMD_CREATE, 4'd5,  1000,   1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    directed[23] = mk_row(CMD_CREATE, 4'd1,  5,      1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
    // table full
    directed[24] = mk_row(CMD_CREATE, 4'd10, 1234,   1'b1, 1'b0, 4'd0, 1'b0, 1'b0);

    burst    = 1'b0;
    phase    = 0;
    t_create = 20;
    t_free   = 45;
    t_p      = 70;
    wait (rst_n);

    for (int n = 0; n < N_DIRECTED + RAND_ITEMS; n++) begin
      if (n < N_DIRECTED) begin
        r = directed[n];
      end else begin
        // new traffic phase every 200 items, burst stretches every 100
        if ((n - N_DIRECTED) % 200 == 0) begin
          phase = $urandom_range(0, 2);
          case (phase)
            0: begin t_create = 20; t_free = 45; t_p = 70; end
            1: begin t_create = 45; t_free = 55; t_p = 75; end
            default: begin t_create = 5; t_free = 45; t_p = 60; end
          endcase
        end
        if ((n - N_DIRECTED) % 100 == 0) burst = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < t_create) it.cmd = CMD_CREATE;
        else if (pick < t_free) it.cmd = CMD_FREE;
        else if (pick < t_p) it.cmd = CMD_P;
        else it.cmd = CMD_V;
        // half the traffic lands on the low slots so counts move around
        it.sem_id = ($urandom_range(0, 1) == 0) ? SLOT_W'($urandom_range(0, 15))
                                                : SLOT_W'($urandom_range(0, 5));
        sel = $urandom_range(0, 9);
        if (sel == 0) it.initial_count = 16'sh7fff;
        else if (sel == 1) it.initial_count = 16'sh8000;
        else if (sel < 4) it.initial_count = 16'($urandom);
        else it.initial_count = 16'($urandom_range(0, 8) - 3);
        r      = '0;
        r.item = it;
      end

      gap = (burst || n < 4) ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= r.item;
      row_lit  <= r.lit;
      row_want <= r.want;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid  <= 1'b0;
    row_lit   <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, bursts with none, and one long hold-off
  initial begin
    int  stall;
    int  taken;
    bit  burst;
    taken = 0;
    burst = 1'b0;
    wait (rst_n);
    forever begin
      if (taken % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      else stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // End of run: drain, let stragglers surface, report
  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d items, %0d results in %0d cycles, incl. a %0d-cycle output hold",
             items_taken, results_taken, cycle_count, HOLD_CYCLES);
    $display("refused creates %0d, released slots %0d, wait flags %0d, wake flags %0d",
             refused_creates, released_slots, wait_flags, wake_flags);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/cst_pkg.sv
src/cst_cell.sv
src/counting_semaphore_table_unit.sv
verif/testbench.sv
